/* rtl/core/scor_pkg.sv */
// Shared types, register indexes, order codes and order decoding for the coordinate remap block.
package scor_pkg;

  localparam int CFG_DATA_W = 32;
  localparam int CFG_IDX_W  = 2;
  localparam int ORDER_W    = 5;
  localparam int BLK_SIZE_W = 4;
  localparam int REM_W      = 3;
  localparam int DIV_CHUNK  = 8;

  localparam logic [CFG_DATA_W-1:0] COUNT_RESET = 32'd1;

  // Order codes as written to the source and target order registers.
  localparam logic [ORDER_W-1:0] ORDER_HORIZONTAL    = 5'd0;
  localparam logic [ORDER_W-1:0] ORDER_VERTICAL      = 5'd1;
  localparam logic [ORDER_W-1:0] ORDER_DIAGONAL      = 5'd2;
  localparam logic [ORDER_W-1:0] ORDER_ANTI_DIAGONAL = 5'd3;
  localparam logic [ORDER_W-1:0] ORDER_ROWBLK_FIRST  = 5'd4;
  localparam logic [ORDER_W-1:0] ORDER_ROWBLK_LAST   = 5'd10;
  localparam logic [ORDER_W-1:0] ORDER_COLBLK_FIRST  = 5'd11;
  localparam logic [ORDER_W-1:0] ORDER_COLBLK_LAST   = 5'd17;
  // Block size is the order code minus these offsets.
  localparam logic [ORDER_W-1:0] ROWBLK_SIZE_OFFSET  = 5'd2;
  localparam logic [ORDER_W-1:0] COLBLK_SIZE_OFFSET  = 5'd9;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ROW_COUNT    = 2'd0,
    REG_COLUMN_COUNT = 2'd1,
    REG_SOURCE_ORDER = 2'd2,
    REG_TARGET_ORDER = 2'd3
  } reg_idx_t;

  typedef enum logic [2:0] {
    ORD_HORIZ  = 3'd0,
    ORD_VERT   = 3'd1,
    ORD_DIAG   = 3'd2,
    ORD_ANTI   = 3'd3,
    ORD_ROWBLK = 3'd4,
    ORD_COLBLK = 3'd5
  } ord_kind_t;

  typedef struct packed {
    ord_kind_t               kind;
    logic [BLK_SIZE_W-1:0]   size;
  } ord_cfg_t;

  // Unknown codes behave as horizontal. Non-block orders carry size one so
  // the dividers always see a nonzero divisor.
  function automatic ord_cfg_t decode_order(input logic [ORDER_W-1:0] code);
    ord_cfg_t d;
    d.kind = ORD_HORIZ;
    d.size = BLK_SIZE_W'(1);
    priority if (code == ORDER_VERTICAL) begin
      d.kind = ORD_VERT;
    end else if (code == ORDER_DIAGONAL) begin
      d.kind = ORD_DIAG;
    end else if (code == ORDER_ANTI_DIAGONAL) begin
      d.kind = ORD_ANTI;
    end else if (code >= ORDER_ROWBLK_FIRST && code <= ORDER_ROWBLK_LAST) begin
      d.kind = ORD_ROWBLK;
      d.size = BLK_SIZE_W'(code - ROWBLK_SIZE_OFFSET);
    end else if (code >= ORDER_COLBLK_FIRST && code <= ORDER_COLBLK_LAST) begin
      d.kind = ORD_COLBLK;
      d.size = BLK_SIZE_W'(code - COLBLK_SIZE_OFFSET);
    end else begin
      d.kind = ORD_HORIZ;
    end
    return d;
  endfunction

endpackage

/* rtl/core/scor_div.sv */
// Pipelined divider of a wide value by a small block size, eight quotient bits per stage.
module scor_div #(
  parameter int W  = 36,
  parameter int SW = 1
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [W-1:0]                       in_num,
  input  logic [scor_pkg::BLK_SIZE_W-1:0]    in_dv,
  input  logic [SW-1:0]                      in_side,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [W-1:0]                       out_quo,
  output logic [scor_pkg::REM_W-1:0]         out_rem,
  output logic [SW-1:0]                      out_side
);

  localparam int CH  = scor_pkg::DIV_CHUNK;
  localparam int RW  = scor_pkg::REM_W;
  localparam int DW  = scor_pkg::BLK_SIZE_W;
  localparam int NST = (W + CH - 1) / CH;
  localparam int PW  = NST * CH;

  // Restoring long division over one chunk; the remainder stays below the
  // divisor, so it never needs more than three bits.
  function automatic logic [CH+RW-1:0] div_step(input logic [CH-1:0] bits,
                                                input logic [RW-1:0] rem,
                                                input logic [DW-1:0] dv);
    logic [RW:0]   t;
    logic [RW-1:0] r;
    logic [CH-1:0] q;
    r = rem;
    q = '0;
    for (int i = CH - 1; i >= 0; i--) begin
      t = {r, bits[i]};
      if (t >= (RW+1)'(dv)) begin
        q[i] = 1'b1;
        r    = RW'(t - (RW+1)'(dv));
      end else begin
        r    = t[RW-1:0];
      end
    end
    return {q, r};
  endfunction

  // Each stage word holds quotient bits above the current chunk position
  // and untouched dividend bits below it.
  logic [PW-1:0] word_r [NST];
  logic [RW-1:0] rem_r  [NST];
  logic [DW-1:0] dv_r   [NST];
  logic [SW-1:0] side_r [NST];
  logic [NST-1:0] vld_r;
  logic [NST:0]   stage_en;

  assign stage_en[NST] = out_ready;
  assign in_ready      = stage_en[0];

  for (genvar k = 0; k < NST; k++) begin : g_stage
    logic          vld_in;
    logic [PW-1:0] word_in;
    logic [RW-1:0] rem_in;
    logic [DW-1:0] dv_in;
    logic [SW-1:0] side_in;
    logic [CH+RW-1:0] step;
    logic [PW-1:0] word_nxt;

    if (k == 0) begin : g_first
      assign vld_in  = in_valid;
      assign word_in = PW'(in_num);
      assign rem_in  = '0;
      assign dv_in   = in_dv;
      assign side_in = in_side;
    end else begin : g_next
      assign vld_in  = vld_r[k-1];
      assign word_in = word_r[k-1];
      assign rem_in  = rem_r[k-1];
      assign dv_in   = dv_r[k-1];
      assign side_in = side_r[k-1];
    end

    assign stage_en[k] = !vld_r[k] || stage_en[k+1];

    always_comb begin
      step     = div_step(word_in[PW-1-CH*k -: CH], rem_in, dv_in);
      word_nxt = word_in;
      word_nxt[PW-1-CH*k -: CH] = step[CH+RW-1:RW];
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else if (stage_en[k]) begin
        vld_r[k] <= vld_in;
      end
    end

    always_ff @(posedge clk) begin
      if (stage_en[k] && vld_in) begin
        word_r[k] <= word_nxt;
        rem_r[k]  <= step[RW-1:0];
        dv_r[k]   <= dv_in;
        side_r[k] <= side_in;
      end
    end
  end

  assign out_valid = vld_r[NST-1];
  assign out_quo   = word_r[NST-1][W-1:0];
  assign out_rem   = rem_r[NST-1];
  assign out_side  = side_r[NST-1];

endmodule

/* rtl/core/sparse_coordinate_order_remap_unit.sv */
// Flow: stage 0, divider 1, stages 2 and 3, divider 2, output register; dividers are pipelined.
// Throughput: one transaction per cycle unless the sink stalls; one 8-bit chunk a divider stage.
// Reset (rst_n low, synchronous): all valid bits clear, row and column counts return to one,
// and both orders return to horizontal. cfg_ready is always high. The user must write
// configuration only while no transaction is in flight; the block does not enforce it.
module sparse_coordinate_order_remap_unit #(
  parameter int COORD_WIDTH = 36
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  // Input stream.
  input  logic                                   in_tvalid,
  output logic                                   in_tready,
  // tdata from bit 0: in_row, in_col, zero fill to whole bytes.
  input  logic [((2*COORD_WIDTH+7)/8)*8-1:0]     in_tdata,
  // Result stream.
  output logic                                   out_tvalid,
  input  logic                                   out_tready,
  // tdata from bit 0: out_row, out_col, zero fill to whole bytes.
  output logic [((2*COORD_WIDTH+7)/8)*8-1:0]     out_tdata,
  // tuser bit 0: zero_coordinate.
  output logic                                   out_tuser,
  // Configuration write channel.
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [scor_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [scor_pkg::CFG_DATA_W-1:0]        cfg_data
);

  localparam int CW  = COORD_WIDTH;
  localparam int TDW = ((2*CW+7)/8)*8;
  localparam int BSW = scor_pkg::BLK_SIZE_W;
  // Comparisons against the 32-bit counts are done at this width so that
  // neither side loses bits.
  localparam int EW  = (CW > scor_pkg::CFG_DATA_W) ? CW : scor_pkg::CFG_DATA_W;

  // Stage payloads.
  typedef struct packed {
    logic [CW-1:0] y;
    logic [CW-1:0] x;
    logic [CW-1:0] ym;
    logic [CW-1:0] xm;
    logic          zero;
  } s0_t;

  typedef struct packed {
    logic [CW-1:0] y;
    logic [CW-1:0] x;
    logic [CW-1:0] ym;
    logic          zero;
  } d1_side_t;

  typedef struct packed {
    logic [CW-1:0] ny;
    logic [CW-1:0] nx;
    logic          zero;
  } s2_t;

  typedef struct packed {
    logic [CW-1:0] ry;
    logic [CW-1:0] rx;
    logic [CW-1:0] bym;
    logic [CW-1:0] bxm;
    logic          zero;
  } s3_t;

  typedef struct packed {
    logic [CW-1:0] ry;
    logic [CW-1:0] rx;
    logic [CW-1:0] bxm;
    logic          zero;
  } d2_side_t;

  typedef struct packed {
    logic [CW-1:0] row;
    logic [CW-1:0] col;
    logic          zero;
  } out_t;

  // ---------------------------------------------------------------------
  // Configuration registers. Orders are kept decoded into a kind and a
  // block size; the raw codes are not needed after the write.
  // ---------------------------------------------------------------------
  logic [scor_pkg::CFG_DATA_W-1:0] row_count_r;
  logic [scor_pkg::CFG_DATA_W-1:0] column_count_r;
  scor_pkg::ord_cfg_t              src_ord_r;
  scor_pkg::ord_cfg_t              tgt_ord_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_count_r    <= scor_pkg::COUNT_RESET;
      column_count_r <= scor_pkg::COUNT_RESET;
      src_ord_r      <= scor_pkg::decode_order(scor_pkg::ORDER_HORIZONTAL);
      tgt_ord_r      <= scor_pkg::decode_order(scor_pkg::ORDER_HORIZONTAL);
    end else if (cfg_valid) begin
      unique case (scor_pkg::reg_idx_t'(cfg_index))
        scor_pkg::REG_ROW_COUNT: begin
          row_count_r <= cfg_data;
        end
        scor_pkg::REG_COLUMN_COUNT: begin
          column_count_r <= cfg_data;
        end
        scor_pkg::REG_SOURCE_ORDER: begin
          src_ord_r <= scor_pkg::decode_order(cfg_data[scor_pkg::ORDER_W-1:0]);
        end
        scor_pkg::REG_TARGET_ORDER: begin
          tgt_ord_r <= scor_pkg::decode_order(cfg_data[scor_pkg::ORDER_W-1:0]);
        end
        default: begin
          row_count_r <= row_count_r;
        end
      endcase
    end
  end

  logic [EW-1:0] rc_e;
  logic [EW-1:0] cc_e;
  assign rc_e = EW'(row_count_r);
  assign cc_e = EW'(column_count_r);

  // ---------------------------------------------------------------------
  // Stall handling: every stage takes a new transaction when it is empty or
  // when the stage after it moves. The chain starts at the output register.
  // ---------------------------------------------------------------------
  logic s0_en, s2_en, s3_en, out_en;
  logic d1_in_ready, d2_in_ready;
  logic d1_vld, d2_vld;

  // ---------------------------------------------------------------------
  // Stage 0: capture the coordinate, flag zeros and form the minus-one
  // values used by the block maps.
  // ---------------------------------------------------------------------
  s0_t  s0_r, s0_nxt;
  logic s0_vld_r;

  assign s0_en     = !s0_vld_r || d1_in_ready;
  assign in_tready = s0_en;

  always_comb begin
    s0_nxt.y    = in_tdata[CW-1:0];
    s0_nxt.x    = in_tdata[2*CW-1:CW];
    s0_nxt.ym   = s0_nxt.y - CW'(1);
    s0_nxt.xm   = s0_nxt.x - CW'(1);
    s0_nxt.zero = (s0_nxt.y == '0) || (s0_nxt.x == '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_vld_r <= 1'b0;
    end else if (s0_en) begin
      s0_vld_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s0_en && in_tvalid) begin
      s0_r <= s0_nxt;
    end
  end

  // ---------------------------------------------------------------------
  // First divider: column minus one over the source block size, as the
  // reverse block map needs it.
  // ---------------------------------------------------------------------
  d1_side_t               d1_side_in, d1_side_out;
  logic [CW-1:0]          d1_quo;
  logic [scor_pkg::REM_W-1:0] d1_rem;

  assign d1_side_in.y    = s0_r.y;
  assign d1_side_in.x    = s0_r.x;
  assign d1_side_in.ym   = s0_r.ym;
  assign d1_side_in.zero = s0_r.zero;

  scor_div #(
    .W  (CW),
    .SW ($bits(d1_side_t))
  ) u_div_src (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (s0_vld_r),
    .in_ready  (d1_in_ready),
    .in_num    (s0_r.xm),
    .in_dv     (src_ord_r.size),
    .in_side   (d1_side_in),
    .out_valid (d1_vld),
    .out_ready (s2_en),
    .out_quo   (d1_quo),
    .out_rem   (d1_rem),
    .out_side  (d1_side_out)
  );

  // ---------------------------------------------------------------------
  // Stage 2: undo the source order to get the natural row and column.
  // ---------------------------------------------------------------------
  s2_t           s2_r, s2_nxt;
  logic          s2_vld_r;
  logic [EW-1:0] sy_e, sx_e;
  logic [CW+BSW-1:0] rev_prod;
  logic [CW-1:0] rev_blk_y, rev_blk_x;

  assign s2_en = !s2_vld_r || s3_en;

  always_comb begin
    sy_e      = EW'(d1_side_out.y);
    sx_e      = EW'(d1_side_out.x);
    rev_prod  = d1_side_out.ym * src_ord_r.size;
    rev_blk_y = rev_prod[CW-1:0] + CW'(d1_rem) + CW'(1);
    rev_blk_x = d1_quo + CW'(1);
    s2_nxt.zero = d1_side_out.zero;
    unique case (src_ord_r.kind)
      scor_pkg::ORD_VERT: begin
        s2_nxt.ny = d1_side_out.x;
        s2_nxt.nx = d1_side_out.y;
      end
      scor_pkg::ORD_DIAG: begin
        if (sy_e < rc_e) begin
          s2_nxt.ny = CW'(rc_e + sx_e - sy_e);
          s2_nxt.nx = d1_side_out.x;
        end else begin
          s2_nxt.ny = d1_side_out.x;
          s2_nxt.nx = CW'(sy_e + sx_e - rc_e);
        end
      end
      scor_pkg::ORD_ANTI: begin
        if (sy_e <= cc_e) begin
          s2_nxt.ny = d1_side_out.x;
          s2_nxt.nx = d1_side_out.y + CW'(1) - d1_side_out.x;
        end else begin
          s2_nxt.ny = CW'(sx_e + sy_e - cc_e);
          s2_nxt.nx = CW'(cc_e + EW'(1) - sx_e);
        end
      end
      scor_pkg::ORD_ROWBLK: begin
        s2_nxt.ny = rev_blk_y;
        s2_nxt.nx = rev_blk_x;
      end
      scor_pkg::ORD_COLBLK: begin
        // Reverse block map, then transpose.
        s2_nxt.ny = rev_blk_x;
        s2_nxt.nx = rev_blk_y;
      end
      default: begin
        s2_nxt.ny = d1_side_out.y;
        s2_nxt.nx = d1_side_out.x;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_vld_r <= 1'b0;
    end else if (s2_en) begin
      s2_vld_r <= d1_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_en && d1_vld) begin
      s2_r <= s2_nxt;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 3: forward map of the target order. Non-block orders finish
  // here; block orders prepare the operands of the second divider.
  // ---------------------------------------------------------------------
  s3_t           s3_r, s3_nxt;
  logic          s3_vld_r;
  logic [EW-1:0] ny_e, nx_e;
  logic [CW-1:0] anti_sum;

  assign s3_en = !s3_vld_r || d2_in_ready;

  always_comb begin
    ny_e     = EW'(s2_r.ny);
    nx_e     = EW'(s2_r.nx);
    anti_sum = s2_r.nx + s2_r.ny - CW'(1);
    s3_nxt.zero = s2_r.zero;
    // Column-block transposes before the block map.
    if (tgt_ord_r.kind == scor_pkg::ORD_COLBLK) begin
      s3_nxt.bym = s2_r.nx - CW'(1);
      s3_nxt.bxm = s2_r.ny - CW'(1);
    end else begin
      s3_nxt.bym = s2_r.ny - CW'(1);
      s3_nxt.bxm = s2_r.nx - CW'(1);
    end
    unique case (tgt_ord_r.kind)
      scor_pkg::ORD_VERT: begin
        s3_nxt.ry = s2_r.nx;
        s3_nxt.rx = s2_r.ny;
      end
      scor_pkg::ORD_DIAG: begin
        s3_nxt.ry = CW'(rc_e + nx_e - ny_e);
        s3_nxt.rx = (s2_r.nx < s2_r.ny) ? s2_r.nx : s2_r.ny;
      end
      scor_pkg::ORD_ANTI: begin
        s3_nxt.ry = anti_sum;
        s3_nxt.rx = (EW'(anti_sum) <= cc_e) ? s2_r.ny : CW'(cc_e + EW'(1) - nx_e);
      end
      default: begin
        s3_nxt.ry = s2_r.ny;
        s3_nxt.rx = s2_r.nx;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_vld_r <= 1'b0;
    end else if (s3_en) begin
      s3_vld_r <= s2_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s3_en && s2_vld_r) begin
      s3_r <= s3_nxt;
    end
  end

  // ---------------------------------------------------------------------
  // Second divider: block-row minus one over the target block size.
  // ---------------------------------------------------------------------
  d2_side_t               d2_side_in, d2_side_out;
  logic [CW-1:0]          d2_quo;
  logic [scor_pkg::REM_W-1:0] d2_rem;

  assign d2_side_in.ry   = s3_r.ry;
  assign d2_side_in.rx   = s3_r.rx;
  assign d2_side_in.bxm  = s3_r.bxm;
  assign d2_side_in.zero = s3_r.zero;

  scor_div #(
    .W  (CW),
    .SW ($bits(d2_side_t))
  ) u_div_tgt (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (s3_vld_r),
    .in_ready  (d2_in_ready),
    .in_num    (s3_r.bym),
    .in_dv     (tgt_ord_r.size),
    .in_side   (d2_side_in),
    .out_valid (d2_vld),
    .out_ready (out_en),
    .out_quo   (d2_quo),
    .out_rem   (d2_rem),
    .out_side  (d2_side_out)
  );

  // ---------------------------------------------------------------------
  // Output register: finish the forward block map and hold the result
  // until the sink takes it.
  // ---------------------------------------------------------------------
  out_t              out_r, out_nxt;
  logic              out_vld_r;
  logic [CW+BSW-1:0] fwd_prod;

  assign out_en = !out_vld_r || out_tready;

  always_comb begin
    fwd_prod     = d2_side_out.bxm * tgt_ord_r.size;
    out_nxt.zero = d2_side_out.zero;
    if (tgt_ord_r.kind == scor_pkg::ORD_ROWBLK || tgt_ord_r.kind == scor_pkg::ORD_COLBLK) begin
      out_nxt.row = d2_quo + CW'(1);
      out_nxt.col = fwd_prod[CW-1:0] + CW'(d2_rem) + CW'(1);
    end else begin
      out_nxt.row = d2_side_out.ry;
      out_nxt.col = d2_side_out.rx;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (out_en) begin
      out_vld_r <= d2_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (out_en && d2_vld) begin
      out_r <= out_nxt;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = TDW'({out_r.col, out_r.row});
  assign out_tuser  = out_r.zero;

endmodule

/* tb/sparse_coordinate_order_remap_checker.sv */
// Checker that predicts and compares every result transaction of the coordinate remap unit.
`timescale 1ns / 1ps

module sparse_coordinate_order_remap_checker #(
  parameter int COORD_WIDTH = 36,
  parameter int TDATA_W     = ((2*COORD_WIDTH+7)/8)*8
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  input  logic                            in_tready,
  input  logic [TDATA_W-1:0]              in_tdata,
  input  logic                            out_tvalid,
  input  logic                            out_tready,
  input  logic [TDATA_W-1:0]              out_tdata,
  input  logic                            out_tuser,
  input  logic                            cfg_valid,
  input  logic                            cfg_ready,
  input  logic [scor_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [scor_pkg::CFG_DATA_W-1:0] cfg_data,
  output int                              mismatch_count,
  output int                              pending_results
);

  typedef logic [COORD_WIDTH-1:0] coord_t;

  typedef struct packed {
    coord_t row;
    coord_t col;
  } coord_pair_t;

  typedef struct packed {
    coord_t row;
    coord_t col;
    logic   zero;
  } remap_result_t;

  logic [scor_pkg::CFG_DATA_W-1:0] row_count_q;
  logic [scor_pkg::CFG_DATA_W-1:0] column_count_q;
  logic [scor_pkg::ORDER_W-1:0]    source_order_q;
  logic [scor_pkg::ORDER_W-1:0]    target_order_q;
  remap_result_t                   remap_expected[$];

  initial begin
    mismatch_count  = 0;
    pending_results = 0;
  end

  // All arithmetic below runs at COORD_WIDTH bits, so every intermediate wraps.
  function automatic coord_pair_t block_forward(input coord_t size, input coord_pair_t p);
    coord_pair_t q;
    coord_t      ym;
    coord_t      xm;
    ym    = p.row - 1'b1;
    xm    = p.col - 1'b1;
    q.row = ym / size + 1'b1;
    q.col = ym % size + size * xm + 1'b1;
    return q;
  endfunction

  function automatic coord_pair_t block_reverse(input coord_t size, input coord_pair_t p);
    coord_pair_t q;
    coord_t      ym;
    coord_t      xm;
    ym    = p.row - 1'b1;
    xm    = p.col - 1'b1;
    q.row = size * ym + xm % size + 1'b1;
    q.col = xm / size + 1'b1;
    return q;
  endfunction

  function automatic coord_pair_t swap_pair(input coord_pair_t p);
    coord_pair_t q;
    q.row = p.col;
    q.col = p.row;
    return q;
  endfunction

  // Recovers the natural coordinate from one given in the source order.
  function automatic coord_pair_t undo_order(input logic [scor_pkg::ORDER_W-1:0] code,
                                             input coord_pair_t p);
    coord_pair_t q;
    coord_t      rows;
    coord_t      cols;
    q    = p;
    rows = coord_t'(row_count_q);
    cols = coord_t'(column_count_q);
    if (code == scor_pkg::ORDER_VERTICAL) begin
      q = swap_pair(p);
    end else if (code == scor_pkg::ORDER_DIAGONAL) begin
      if (p.row < rows) begin
        q.col = p.col;
        q.row = rows + p.col - p.row;
      end else begin
        q.row = p.col;
        q.col = p.row + p.col - rows;
      end
    end else if (code == scor_pkg::ORDER_ANTI_DIAGONAL) begin
      if (p.row <= cols) begin
        q.row = p.col;
        q.col = p.row + 1'b1 - p.col;
      end else begin
        q.row = p.col + p.row - cols;
        q.col = cols + 1'b1 - p.col;
      end
    end else if (code >= scor_pkg::ORDER_ROWBLK_FIRST &&
                 code <= scor_pkg::ORDER_ROWBLK_LAST) begin
      q = block_reverse(coord_t'(code - scor_pkg::ROWBLK_SIZE_OFFSET), p);
    end else if (code >= scor_pkg::ORDER_COLBLK_FIRST &&
                 code <= scor_pkg::ORDER_COLBLK_LAST) begin
      q = swap_pair(block_reverse(coord_t'(code - scor_pkg::COLBLK_SIZE_OFFSET), p));
    end
    return q;
  endfunction

  // Maps a natural coordinate into the target order.
  function automatic coord_pair_t apply_order(input logic [scor_pkg::ORDER_W-1:0] code,
                                              input coord_pair_t p);
    coord_pair_t q;
    coord_t      rows;
    coord_t      cols;
    coord_t      sum;
    q    = p;
    rows = coord_t'(row_count_q);
    cols = coord_t'(column_count_q);
    if (code == scor_pkg::ORDER_VERTICAL) begin
      q = swap_pair(p);
    end else if (code == scor_pkg::ORDER_DIAGONAL) begin
      q.row = rows + p.col - p.row;
      q.col = (p.col < p.row) ? p.col : p.row;
    end else if (code == scor_pkg::ORDER_ANTI_DIAGONAL) begin
      sum   = p.col + p.row - 1'b1;
      q.row = sum;
      q.col = (sum <= cols) ? p.row : cols + 1'b1 - p.col;
    end else if (code >= scor_pkg::ORDER_ROWBLK_FIRST &&
                 code <= scor_pkg::ORDER_ROWBLK_LAST) begin
      q = block_forward(coord_t'(code - scor_pkg::ROWBLK_SIZE_OFFSET), p);
    end else if (code >= scor_pkg::ORDER_COLBLK_FIRST &&
                 code <= scor_pkg::ORDER_COLBLK_LAST) begin
      q = block_forward(coord_t'(code - scor_pkg::COLBLK_SIZE_OFFSET), swap_pair(p));
    end
    return q;
  endfunction

  function automatic remap_result_t remap_coordinate(input coord_t row, input coord_t col);
    coord_pair_t   p;
    remap_result_t r;
    p.row  = row;
    p.col  = col;
    p      = apply_order(target_order_q, undo_order(source_order_q, p));
    r.row  = p.row;
    r.col  = p.col;
    r.zero = (row == '0) || (col == '0);
    return r;
  endfunction

  always @(posedge clk) begin : watch
    remap_result_t want;
    remap_result_t got;
    remap_result_t item;
    if (!rst_n) begin
      row_count_q    = scor_pkg::COUNT_RESET;
      column_count_q = scor_pkg::COUNT_RESET;
      source_order_q = scor_pkg::ORDER_HORIZONTAL;
      target_order_q = scor_pkg::ORDER_HORIZONTAL;
      remap_expected.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (scor_pkg::reg_idx_t'(cfg_index))
          scor_pkg::REG_ROW_COUNT:    row_count_q    = cfg_data;
          scor_pkg::REG_COLUMN_COUNT: column_count_q = cfg_data;
          scor_pkg::REG_SOURCE_ORDER: source_order_q = cfg_data[scor_pkg::ORDER_W-1:0];
          scor_pkg::REG_TARGET_ORDER: target_order_q = cfg_data[scor_pkg::ORDER_W-1:0];
          default: ;
        endcase
      end
      if (in_tvalid && in_tready) begin
        item = remap_coordinate(in_tdata[COORD_WIDTH-1:0],
                                in_tdata[2*COORD_WIDTH-1:COORD_WIDTH]);
        remap_expected.insert(remap_expected.size(), item);
      end
      if (out_tvalid && out_tready) begin
        got.row  = out_tdata[COORD_WIDTH-1:0];
        got.col  = out_tdata[2*COORD_WIDTH-1:COORD_WIDTH];
        got.zero = out_tuser;
        if (remap_expected.size() == 0) begin
          mismatch_count++;
          $display("%0t: expected none, actual row=%h col=%h zero=%b",
                   $time, got.row, got.col, got.zero);
        end else begin
          want = remap_expected.pop_front();
          if (got !== want) begin
            mismatch_count++;
            $display("%0t: expected row=%h col=%h zero=%b, actual row=%h col=%h zero=%b",
                     $time, want.row, want.col, want.zero, got.row, got.col, got.zero);
          end
        end
      end
    end
    pending_results = remap_expected.size();
  end

endmodule

/* tb/sparse_coordinate_order_remap_unit_test.sv */
// Top of the coordinate remap testbench: clock, reset, stimulus, backpressure and the verdict.
`timescale 1ns / 1ps

module sparse_coordinate_order_remap_unit_test;

  localparam int COORD_W      = 36;
  localparam int TDATA_W      = ((2*COORD_W+7)/8)*8;
  localparam int RESET_CYCLES = 4;
  // The settle time covers the full pipeline depth at this width with margin.
  localparam int SETTLE_CYCLES = 24;
  localparam int CYCLE_LIMIT   = 200000;
  localparam int RANDOM_PHASES = 36;
  localparam int PHASE_ITEMS   = 40;
  // The phase in which neither side idles at all.
  localparam int STEADY_PHASE  = 5;
  localparam int IDLE_PERCENT  = 20;

  // Codes above the last column-block order decode as horizontal.
  localparam logic [scor_pkg::ORDER_W-1:0] ORDER_UNKNOWN_FIRST =
    scor_pkg::ORDER_COLBLK_LAST + 1'b1;
  localparam logic [scor_pkg::ORDER_W-1:0] ORDER_UNKNOWN_LAST  = '1;

  typedef logic [COORD_W-1:0] coord_t;

  localparam coord_t COORD_MAX  = '1;
  localparam coord_t COORD_ODDS = 36'h5_5555_5555;
  localparam coord_t COORD_EVNS = 36'hA_AAAA_AAAA;
  localparam logic [scor_pkg::CFG_DATA_W-1:0] COUNT_MAX = '1;

  logic                            clk = 1'b0;
  logic                            rst_n;
  logic                            in_tvalid;
  logic                            in_tready;
  logic [TDATA_W-1:0]              in_tdata;
  logic                            out_tvalid;
  logic                            out_tready = 1'b0;
  logic [TDATA_W-1:0]              out_tdata;
  logic                            out_tuser;
  logic                            cfg_valid;
  logic                            cfg_ready;
  logic [scor_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [scor_pkg::CFG_DATA_W-1:0] cfg_data;

  int                              mismatch_count;
  int                              pending_results;
  int                              cycle_count = 0;
  bit                              steady = 1'b0;

  // Counts currently programmed, used to aim coordinates at the branch points.
  logic [scor_pkg::CFG_DATA_W-1:0] cur_rows;
  logic [scor_pkg::CFG_DATA_W-1:0] cur_cols;

  always #5 clk = ~clk;

  sparse_coordinate_order_remap_unit #(
    .COORD_WIDTH(COORD_W)
  ) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  sparse_coordinate_order_remap_checker #(
    .COORD_WIDTH(COORD_W)
  ) u_remap_check (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_tvalid       (in_tvalid),
    .in_tready       (in_tready),
    .in_tdata        (in_tdata),
    .out_tvalid      (out_tvalid),
    .out_tready      (out_tready),
    .out_tdata       (out_tdata),
    .out_tuser       (out_tuser),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .mismatch_count  (mismatch_count),
    .pending_results (pending_results)
  );

  // The receiver stalls in about one cycle out of five, except in the steady phase.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      out_tready <= steady || ($urandom_range(0, 99) >= IDLE_PERCENT);
    end
  end

  // A hung handshake or a lost result ends the run here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // Writes one register. The caller lowers cfg_valid after its last write, so that
  // back-to-back writes never lower and raise valid within the same time step.
  // Ready is sampled at the falling edge, where it is stable, and the transaction
  // completes at the next rising edge.
  task automatic write_register(input scor_pkg::reg_idx_t idx,
                                input logic [scor_pkg::CFG_DATA_W-1:0] value);
    logic ok;
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do begin
      @(negedge clk);
      ok = cfg_ready;
      @(posedge clk);
    end while (!ok);
  endtask

  // Programs all four registers. Only called while nothing is in flight.
  task automatic program_orders(input logic [scor_pkg::CFG_DATA_W-1:0] rows,
                                input logic [scor_pkg::CFG_DATA_W-1:0] cols,
                                input logic [scor_pkg::ORDER_W-1:0]    src,
                                input logic [scor_pkg::ORDER_W-1:0]    dst);
    write_register(scor_pkg::REG_ROW_COUNT, rows);
    write_register(scor_pkg::REG_COLUMN_COUNT, cols);
    write_register(scor_pkg::REG_SOURCE_ORDER, scor_pkg::CFG_DATA_W'(src));
    write_register(scor_pkg::REG_TARGET_ORDER, scor_pkg::CFG_DATA_W'(dst));
    cfg_valid <= 1'b0;
    cur_rows = rows;
    cur_cols = cols;
  endtask

  // Sends one coordinate transaction. Before it the sender may idle at random,
  // showing junk on tdata that the block must ignore while tvalid is low.
  task automatic send_coord(input coord_t row, input coord_t col);
    logic ok;
    while (!steady && $urandom_range(0, 99) < IDLE_PERCENT) begin
      in_tvalid <= 1'b0;
      in_tdata  <= TDATA_W'({$urandom, $urandom, $urandom});
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= TDATA_W'({col, row});
    do begin
      @(negedge clk);
      ok = in_tready;
      @(posedge clk);
    end while (!ok);
  endtask

  // Holds off the sender until every expected result has come back, then lets the
  // pipeline settle before any register is touched.
  task automatic wait_drained();
    in_tvalid <= 1'b0;
    do begin
      @(negedge clk);
    end while (pending_results != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Picks a coordinate: small values most often, for the block orders; values at and around the
  // programmed count for the diagonal branch points; edge values and full-width noise.
  function automatic coord_t pick_coord(input logic [scor_pkg::CFG_DATA_W-1:0] bound);
    coord_t v;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: v = coord_t'($urandom_range(1, 40));
      4, 5:       v = coord_t'(bound) + coord_t'($urandom_range(0, 4)) - coord_t'(2);
      6: begin
        case ($urandom_range(0, 2))
          0:       v = '0;
          1:       v = coord_t'(1);
          default: v = COORD_MAX;
        endcase
      end
      default:    v = coord_t'({$urandom, $urandom});
    endcase
    return v;
  endfunction

  function automatic logic [scor_pkg::CFG_DATA_W-1:0] pick_count();
    logic [scor_pkg::CFG_DATA_W-1:0] c;
    case ($urandom_range(0, 3))
      0:       c = scor_pkg::COUNT_RESET;
      1:       c = COUNT_MAX;
      2:       c = scor_pkg::CFG_DATA_W'($urandom_range(2, 64));
      default: c = $urandom;
    endcase
    if (c == '0) begin
      c = scor_pkg::COUNT_RESET;
    end
    return c;
  endfunction

  // Mostly defined orders, with the undefined codes that must act as horizontal mixed in.
  function automatic logic [scor_pkg::ORDER_W-1:0] pick_order();
    logic [scor_pkg::ORDER_W-1:0] code;
    if ($urandom_range(0, 99) < 85) begin
      code = scor_pkg::ORDER_W'($urandom_range(scor_pkg::ORDER_HORIZONTAL,
                                               scor_pkg::ORDER_COLBLK_LAST));
    end else begin
      code = scor_pkg::ORDER_W'($urandom_range(ORDER_UNKNOWN_FIRST, ORDER_UNKNOWN_LAST));
    end
    return code;
  endfunction

  initial begin : stimulus
    logic [scor_pkg::ORDER_W-1:0]    src;
    logic [scor_pkg::ORDER_W-1:0]    dst;
    logic [scor_pkg::CFG_DATA_W-1:0] bound;
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    cfg_valid = 1'b0;
    cfg_index = scor_pkg::REG_ROW_COUNT;
    cfg_data  = '0;
    cur_rows  = scor_pkg::COUNT_RESET;
    cur_cols  = scor_pkg::COUNT_RESET;

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part, first with the reset settings: identity in both directions.
    // Zero coordinates in each field, all-ones and alternating bit patterns.
    send_coord('0, '0);
    send_coord('0, COORD_MAX);
    send_coord(COORD_MAX, '0);
    send_coord(coord_t'(1), coord_t'(1));
    send_coord(COORD_MAX, COORD_MAX);
    send_coord(COORD_ODDS, COORD_EVNS);
    send_coord(COORD_EVNS, COORD_ODDS);
    wait_drained();

    // Diagonal into anti-diagonal with the largest counts. The second item sits right
    // at the row count, where the diagonal reverse map switches branches.
    program_orders(COUNT_MAX, COUNT_MAX, scor_pkg::ORDER_DIAGONAL,
                   scor_pkg::ORDER_ANTI_DIAGONAL);
    send_coord(coord_t'(1), coord_t'(1));
    send_coord(coord_t'(COUNT_MAX), coord_t'(5));
    send_coord(coord_t'(COUNT_MAX) - 1'b1, coord_t'(3));
    send_coord('0, coord_t'(7));
    send_coord(COORD_MAX, COORD_MAX);
    wait_drained();

    // An undefined source code acts as identity; the target is the widest column block.
    program_orders(scor_pkg::COUNT_RESET, scor_pkg::COUNT_RESET, ORDER_UNKNOWN_LAST,
                   scor_pkg::ORDER_COLBLK_LAST);
    send_coord(coord_t'(3), coord_t'(9));
    send_coord('0, coord_t'(1));
    send_coord(COORD_MAX, coord_t'(2));
    wait_drained();

    // Smallest row block back into a transpose.
    program_orders(scor_pkg::CFG_DATA_W'(7), scor_pkg::CFG_DATA_W'(3),
                   scor_pkg::ORDER_ROWBLK_FIRST, scor_pkg::ORDER_VERTICAL);
    send_coord(coord_t'(2), coord_t'(5));
    send_coord(coord_t'(1), coord_t'(1));
    send_coord(coord_t'(9), COORD_MAX);
    wait_drained();

    // Smallest column block into the tallest row block.
    program_orders(scor_pkg::CFG_DATA_W'(5), scor_pkg::CFG_DATA_W'(5),
                   scor_pkg::ORDER_COLBLK_FIRST, scor_pkg::ORDER_ROWBLK_LAST);
    send_coord(coord_t'(4), coord_t'(4));
    send_coord(coord_t'(1), coord_t'(9));
    wait_drained();

    // Random part. The first 32 phases walk every code through the source register and,
    // in a scrambled sequence, through the target register; later phases pick at random.
    // Each phase boundary drains the pipeline completely before reprogramming.
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      if (p < 32) begin
        src = scor_pkg::ORDER_W'(p);
        dst = scor_pkg::ORDER_W'(p * 7 + 3);
      end else begin
        src = pick_order();
        dst = pick_order();
      end
      program_orders(pick_count(), pick_count(), src, dst);
      steady = (p == STEADY_PHASE);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        bound = $urandom_range(0, 1) ? cur_rows : cur_cols;
        send_coord(pick_coord(bound), pick_coord(bound));
      end
      wait_drained();
      steady = 1'b0;
    end

    // wait_drained left nothing outstanding; a leftover count here still fails.
    if (mismatch_count == 0 && pending_results == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
